// File: hdl/sad_stereo_disparity_macros.svh
// Assertion macros for the SAD stereo disparity block.
// Used by the port checker; needs i_clk and i_rst_n in scope.
`ifndef SAD_STEREO_DISPARITY_MACROS_SVH
`define SAD_STEREO_DISPARITY_MACROS_SVH

`define SADSD_CLKED(prop) @(posedge i_clk) disable iff (!i_rst_n) prop

`define SADSD_ASSERT(label, prop, msg) \
    label: assert property (`SADSD_CLKED(prop)) else $error(msg);

`endif

// File: hdl/sadsd_pkg.sv
// Shared types and constants for the SAD stereo disparity block.
// No dependencies.
`default_nettype none
package sadsd_pkg;
    localparam int PIX_W      = 8;
    localparam int DISP_W     = 6;
    localparam int ROW_W      = 10;
    localparam int CFG_W      = 11;
    localparam int MAX_HEIGHT = 1024;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

    typedef enum logic [1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_HALF_WIN = 2'd2,
        CFG_DISP_CNT = 2'd3
    } t_cfg_idx;
endpackage
`default_nettype wire

// File: hdl/sadsd_linestore.sv
// Left and right line stores: one write port, one registered read port each.
// Depends on sadsd_pkg.
`default_nettype none
module sadsd_linestore
    import sadsd_pkg::*;
#(
    parameter int LINES     = 15,
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [PIX_W-1:0] i_wdata_l,
    input  wire logic [PIX_W-1:0] i_wdata_r,
    input  wire logic [AW-1:0]    i_raddr_l,
    input  wire logic [AW-1:0]    i_raddr_r,
    output logic      [PIX_W-1:0] o_rdata_l,
    output logic      [PIX_W-1:0] o_rdata_r
);
    logic [PIX_W-1:0] r_mem_l [LINES*MAX_WIDTH];
    logic [PIX_W-1:0] r_mem_r [LINES*MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_l[i_waddr] <= i_wdata_l;
            r_mem_r[i_waddr] <= i_wdata_r;
        end
        o_rdata_l <= r_mem_l[i_raddr_l];
        o_rdata_r <= r_mem_r[i_raddr_r];
    end
endmodule
`default_nettype wire

// File: hdl/sadsd_search.sv
// Disparity search sequencer: walks candidates and window taps through the
// line stores and keeps the lowest SAD. Depends on sadsd_pkg.
`default_nettype none
module sadsd_search
    import sadsd_pkg::*;
#(
    parameter int LINES = 15,
    parameter int LW    = 4,
    parameter int CW    = 10,
    parameter int HW    = 3,
    parameter int DW    = 7,
    parameter int SW    = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [LW-1:0]    i_line,
    input  wire logic [CW-1:0]    i_col,
    input  wire logic [HW-1:0]    i_hw,
    input  wire logic [DW-1:0]    i_dlast,
    output logic      [LW+CW-1:0] o_raddr_l,
    output logic      [LW+CW-1:0] o_raddr_r,
    input  wire logic [PIX_W-1:0] i_rdata_l,
    input  wire logic [PIX_W-1:0] i_rdata_r,
    output logic                  o_done,
    output logic      [DW-1:0]    o_best_d
);
    logic          r_busy;
    logic [DW-1:0] r_d, r_dlast;
    logic [LW-1:0] r_dy, r_dx, r_hw2, r_line, r_line0;
    logic [CW-1:0] r_col, r_col0;
    logic          r_p_valid, r_p_first, r_p_lastw, r_p_final;
    logic [DW-1:0] r_p_d;
    logic [SW-1:0] r_acc, r_best;
    logic          r_done;
    logic          lastw;
    logic [PIX_W-1:0] diff;
    logic [SW-1:0]    sum;

    assign lastw     = (r_dx == r_hw2) && (r_dy == r_hw2);
    assign o_raddr_l = {r_line, r_col};
    assign o_raddr_r = {r_line, r_col - CW'(r_d)};
    assign diff      = (i_rdata_l > i_rdata_r) ? i_rdata_l - i_rdata_r
                                               : i_rdata_r - i_rdata_l;
    assign sum       = (r_p_first ? SW'(0) : r_acc) + SW'(diff);
    assign o_done    = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_p_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_p_valid <= r_busy;
            r_done    <= r_p_valid && r_p_final;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && lastw && (r_d == r_dlast)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d     <= '0;
            r_dy    <= '0;
            r_dx    <= '0;
            r_line  <= i_line;
            r_line0 <= i_line;
            r_col   <= i_col;
            r_col0  <= i_col;
            r_hw2   <= LW'({i_hw, 1'b0});
            r_dlast <= i_dlast;
        end else if (r_busy) begin
            if (r_dx != r_hw2) begin
                r_dx  <= r_dx + LW'(1);
                r_col <= r_col + CW'(1);
            end else begin
                r_dx  <= '0;
                r_col <= r_col0;
                if (r_dy != r_hw2) begin
                    r_dy   <= r_dy + LW'(1);
                    r_line <= (r_line == LW'(LINES - 1)) ? '0 : r_line + LW'(1);
                end else begin
                    r_dy   <= '0;
                    r_line <= r_line0;
                    r_d    <= r_d + DW'(1);
                end
            end
        end
        r_p_first <= (r_dx == '0) && (r_dy == '0);
        r_p_lastw <= lastw;
        r_p_final <= lastw && (r_d == r_dlast);
        r_p_d     <= r_d;
        if (r_p_valid) begin
            r_acc <= sum;
            if (r_p_lastw && ((r_p_d == '0) || (sum < r_best))) begin
                r_best   <= sum;
                o_best_d <= r_p_d;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/sad_stereo_disparity.sv
// SAD stereo disparity top level. Pixel beats without a result, border and
// drain results need no search; an interior result runs the search over
// n candidates, one window tap per cycle through the line-store
// read port. Reset clears counters, state and configuration to defaults; the line stores
// are not cleared. Depends on sadsd_pkg, sadsd_linestore, sadsd_search.
`default_nettype none
module sad_stereo_disparity
    import sadsd_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HALF_WIN = 7,
    parameter int DISP_CAP     = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_action,
    input  wire logic [PIX_W-1:0]  i_left_pixel,
    input  wire logic [PIX_W-1:0]  i_right_pixel,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DISP_W-1:0] o_disparity,
    output logic                   o_last_pixel,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);
    localparam int LINES = 2 * MAX_HALF_WIN + 1;
    localparam int LW    = $clog2(LINES);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = WW + 1;
    localparam int HW    = $clog2(MAX_HALF_WIN + 1);
    localparam int DW    = $clog2(DISP_CAP + 1);
    localparam int AW    = LW + CW;
    localparam int SW    = $clog2(LINES * LINES * 255 + 1);
    localparam int QW    = $clog2(MAX_WIDTH * MAX_HEIGHT);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_w, r_cfg_ht;
    logic [2:0]       r_cfg_hw;
    logic [6:0]       r_cfg_md;

    logic [CW-1:0]    r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row, r_out_row;
    logic [LW-1:0]    r_in_line, r_out_line;
    logic [QW-1:0]    r_in_pos;
    logic             r_fc;
    logic             r_out_valid, r_out_last, r_pend_last;
    logic [DISP_W-1:0] r_out_disp;

    logic [WW-1:0]    eff_w;
    logic [CFG_W-1:0] eff_ht;
    logic [HW-1:0]    eff_hw;
    logic [DW-1:0]    eff_md;
    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] ht_last;
    logic [QW-1:0]    lag;

    logic             in_acc, cfg_acc, is_pix, in_frame_end, past_lag, do_emit;
    logic [CW-1:0]    em_col, xh;
    logic [ROW_W-1:0] em_row;
    logic [LW-1:0]    em_line, start_line;
    logic             em_last, border, zero_res, srch_start;
    logic [DW-1:0]    dlast;

    logic [AW-1:0]    raddr_l, raddr_r;
    logic [PIX_W-1:0] rdata_l, rdata_r;
    logic             srch_done;
    logic [DW-1:0]    best_d;

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_ht == '0) begin
            eff_ht = CFG_W'(1);
        end else if (32'(r_cfg_ht) > 32'(MAX_HEIGHT)) begin
            eff_ht = CFG_W'(MAX_HEIGHT);
        end else begin
            eff_ht = r_cfg_ht;
        end
        eff_hw  = (32'(r_cfg_hw) > 32'(MAX_HALF_WIN)) ? HW'(MAX_HALF_WIN) : HW'(r_cfg_hw);
        eff_md  = (32'(r_cfg_md) > 32'(DISP_CAP)) ? DW'(DISP_CAP) : DW'(r_cfg_md);
        w_last  = CW'(eff_w - WW'(1));
        ht_last = ROW_W'(eff_ht - CFG_W'(1));
        lag     = QW'(eff_hw) * QW'(eff_w) + QW'(eff_hw);
    end

    assign o_ready     = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign is_pix      = (i_action == ACT_PIXEL);

    always_comb begin
        in_frame_end = (r_in_col == w_last) && (r_in_row == ht_last);
        past_lag     = (r_in_pos >= lag);
        do_emit      = in_acc && (is_pix ? past_lag : r_fc);
        if (is_pix && r_fc) begin
            em_col  = '0;
            em_row  = '0;
            em_line = '0;
        end else begin
            em_col  = r_out_col;
            em_row  = r_out_row;
            em_line = r_out_line;
        end
        em_last  = (em_col == w_last) && (em_row == ht_last);
        border   = (em_row < ROW_W'(eff_hw))
                || (CFG_W'(em_row) + CFG_W'(eff_hw) >= eff_ht)
                || (em_col < CW'(eff_hw))
                || (XW'(em_col) + XW'(eff_hw) >= XW'(eff_w));
        zero_res = border || (eff_md == '0);
        xh       = em_col - CW'(eff_hw);
        dlast    = (32'(xh) >= 32'(eff_md) - 32'd1) ? eff_md - DW'(1) : DW'(xh);
        start_line = (em_line >= LW'(eff_hw)) ? em_line - LW'(eff_hw)
                                              : em_line + LW'(LINES) - LW'(eff_hw);
        srch_start = do_emit && !zero_res;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (srch_start) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (srch_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= CFG_W'(640);
            r_cfg_ht    <= CFG_W'(480);
            r_cfg_hw    <= 3'd3;
            r_cfg_md    <= 7'd64;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_line   <= '0;
            r_in_pos    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_line  <= '0;
            r_fc        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                if (do_emit) begin
                    if (em_last) begin
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                        r_out_line <= '0;
                    end else if (em_col == w_last) begin
                        r_out_col  <= '0;
                        r_out_row  <= em_row + ROW_W'(1);
                        r_out_line <= (em_line == LW'(LINES - 1)) ? '0 : em_line + LW'(1);
                    end else begin
                        r_out_col  <= em_col + CW'(1);
                        r_out_row  <= em_row;
                        r_out_line <= em_line;
                    end
                    if (zero_res) begin
                        r_out_valid <= 1'b1;
                        r_out_disp  <= '0;
                        r_out_last  <= em_last;
                    end
                end else begin
                    r_out_col  <= em_col;
                    r_out_row  <= em_row;
                    r_out_line <= em_line;
                end
                if (is_pix) begin
                    r_fc <= in_frame_end && !(do_emit && em_last);
                    if (in_frame_end) begin
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_in_line <= '0;
                        r_in_pos  <= '0;
                    end else begin
                        r_in_pos <= r_in_pos + QW'(1);
                        if (r_in_col == w_last) begin
                            r_in_col  <= '0;
                            r_in_row  <= r_in_row + ROW_W'(1);
                            r_in_line <= (r_in_line == LW'(LINES - 1)) ? '0
                                                                        : r_in_line + LW'(1);
                        end else begin
                            r_in_col <= r_in_col + CW'(1);
                        end
                    end
                end else if (do_emit && em_last) begin
                    r_fc <= 1'b0;
                end
            end
            if (srch_done) begin
                r_out_valid <= 1'b1;
                r_out_disp  <= DISP_W'(best_d);
                r_out_last  <= r_pend_last;
            end
            if (cfg_acc) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:    r_cfg_w  <= i_cfg_data;
                    CFG_HEIGHT:   r_cfg_ht <= i_cfg_data;
                    CFG_HALF_WIN: r_cfg_hw <= i_cfg_data[2:0];
                    CFG_DISP_CNT: r_cfg_md <= i_cfg_data[6:0];
                    default:      r_cfg_w  <= r_cfg_w;
                endcase
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_line  <= '0;
                r_in_pos   <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_line <= '0;
                r_fc       <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (srch_start) begin
            r_pend_last <= em_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_disparity  = r_out_disp;
    assign o_last_pixel = r_out_last;

    sadsd_linestore #(
        .LINES     (LINES),
        .MAX_WIDTH (2 ** CW),
        .AW        (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (in_acc && is_pix),
        .i_waddr   ({r_in_line, r_in_col}),
        .i_wdata_l (i_left_pixel),
        .i_wdata_r (i_right_pixel),
        .i_raddr_l (raddr_l),
        .i_raddr_r (raddr_r),
        .o_rdata_l (rdata_l),
        .o_rdata_r (rdata_r)
    );

    sadsd_search #(
        .LINES (LINES),
        .LW    (LW),
        .CW    (CW),
        .HW    (HW),
        .DW    (DW),
        .SW    (SW)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (srch_start),
        .i_line    (start_line),
        .i_col     (xh),
        .i_hw      (eff_hw),
        .i_dlast   (dlast),
        .o_raddr_l (raddr_l),
        .o_raddr_r (raddr_r),
        .i_rdata_l (rdata_l),
        .i_rdata_r (rdata_r),
        .o_done    (srch_done),
        .o_best_d  (best_d)
    );
endmodule
`default_nettype wire

// File: hdl/sadsd_checker.sv
// Port-level checks for sad_stereo_disparity, bound to the top level.
// Depends on sad_stereo_disparity_macros.svh.
`default_nettype none
`include "sad_stereo_disparity_macros.svh"
module sadsd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       i_action,
    input wire logic [7:0] i_left_pixel,
    input wire logic [7:0] i_right_pixel,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [5:0] o_disparity,
    input wire logic       o_last_pixel,
    input wire logic       i_cfg_valid,
    input wire logic       o_cfg_ready,
    input wire logic [1:0] i_cfg_index,
    input wire logic [10:0] i_cfg_data
);
    `SADSD_ASSERT(a_ready_idle, o_ready |-> o_cfg_ready, "input ready while busy")
    `SADSD_ASSERT(a_reset_empty, $past(!i_rst_n) |-> !o_valid, "result beat after reset")
    `SADSD_ASSERT(a_slot_free, (o_ready && o_valid) |-> i_ready, "input taken over full slot")
    `SADSD_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_disparity) && $stable(o_last_pixel)), "stalled beat changed")
endmodule

bind sad_stereo_disparity sadsd_checker u_chk (.*);
`default_nettype wire
